// ===== hdl/wpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types and codes of the wildcard pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

	// item kinds carried on tuser
	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TEXT    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// configuration register indexes
	localparam logic REG_JOKER  = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	// register reset values
	localparam logic [7:0] JOKER_RESET  = 8'd63;
	localparam logic [6:0] LENGTH_RESET = 7'd1;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// per-cell controls for one cycle
	typedef struct packed {
		logic shift;   // text byte moves one cell up
		logic clear;   // restart wipes the text byte
		logic pat_we;  // pattern byte of this cell is written
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/wpm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_cell
// one position of the matcher: text byte, pattern byte and compare
// ----------------------------------------------------------------------------
module wpm_cell
	import wpm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic [7:0] shift_in,
	input  wire logic [7:0] pat_in,
	input  wire logic [7:0] joker,
	input  wire logic      in_use,
	input  wire logic [7:0] cmp_text,
	output logic     [7:0] shift_out,
	output logic           hit_s2
);

	logic [7:0] text_q;
	logic [7:0] pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q <= '0;
		end else if (ctl.clear) begin
			text_q <= '0;
		end else if (ctl.shift) begin
			text_q <= shift_in;
		end
	end

	// pattern byte, undefined until written
	always_ff @(posedge clk) begin
		if (ctl.pat_we) begin
			pat_q <= pat_in;
		end
	end

	// positions beyond the pattern length always agree
	always_ff @(posedge clk) begin
		hit_s2 <= !in_use || (pat_q == joker) || (pat_q == cmp_text);
	end

	assign shift_out = text_q;

endmodule
`default_nettype wire

// ===== hdl/wpm_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_out_fifo
// small queue of reported match positions in front of the master port
// ----------------------------------------------------------------------------
module wpm_out_fifo
	import wpm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [31:0]           push_data,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,
	output logic [FIFO_CNT_W-1:0]      count
);

	logic [31:0]           mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = mem_q[rd_ptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wildcard_pattern_matcher_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// streaming matcher of one pattern with a wildcard byte against a text stream
// ----------------------------------------------------------------------------
// Items arrive on the slave port with a kind in tuser: a pattern write stores
// char_value at pattern_index, a text byte moves the text window by one, and a
// restart clears the window, the position counter and the last reported start
// (pattern and registers stay). Once pattern_length text bytes have been seen,
// each text byte closes a window; if every non-joker pattern byte equals the
// text byte at its offset and the window does not overlap the previous report,
// the 1-based start position comes out on the master port. The block takes one
// item per clock while tready is high: the row of PATTERN_MAX cells shifts the
// window and compares all positions in parallel; a result passes stage 1, the
// stage 2 compare and the result queue. tready drops only while the four-entry
// result queue plus the text bytes still in the two pipeline stages would fill
// that queue, so the rate stays at one item a cycle as long as the master side
// keeps up. The position counter saturates at 2^32-1. The user must write the
// registers only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core
	import wpm_pkg::*;
#(
	parameter int PATTERN_MAX = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [5:0] pattern_index, [13:6] char_value, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] match_position
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int WIN_W = PATTERN_MAX * 8;

	// configuration registers
	logic [7:0] joker_q;
	logic [6:0] pattern_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joker_q          <= JOKER_RESET;
			pattern_length_q <= LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JOKER:  joker_q          <= cfg_data;
				REG_LENGTH: pattern_length_q <= cfg_data[6:0];
				default:    ;
			endcase
		end
	end

	// length in use: zero counts as one, capped at the cell count
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		if (pattern_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(pattern_length_q) > PATTERN_MAX) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = LEN_W'(pattern_length_q);
		end
	end

	// input item decode
	logic       in_acc;
	logic [5:0] pattern_index;
	logic [7:0] char_value;
	logic       acc_pattern;
	logic       acc_text;
	logic       acc_restart;

	assign in_acc        = s_tvalid && s_tready;
	assign pattern_index = s_tdata[5:0];
	assign char_value    = s_tdata[13:6];
	assign acc_pattern   = in_acc && (s_tuser == OP_PATTERN);
	assign acc_text      = in_acc && (s_tuser == OP_TEXT);
	assign acc_restart   = in_acc && (s_tuser == OP_RESTART);

	// text position counter, saturating
	logic [31:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc_restart) begin
			count_q <= '0;
		end else if (acc_text && (count_q != '1)) begin
			count_q <= count_q + 32'd1;
		end
	end

	// stage 1: window just shifted, count_q belongs to this item
	logic txt_s1;
	logic rst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_s1 <= 1'b0;
			rst_s1 <= 1'b0;
		end else begin
			txt_s1 <= acc_text;
			rst_s1 <= acc_restart;
		end
	end

	// window as seen by the pattern: entry k of the pattern meets window byte len-1-k
	logic [WIN_W-1:0] win_rev;
	logic [WIN_W-1:0] aligned;
	logic [IDX_W-1:0] align_sh;
	logic [7:0]       chain [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit_s2;

	assign align_sh = IDX_W'(32'(PATTERN_MAX) - 32'(len_eff));
	assign aligned  = win_rev >> (32'(align_sh) << 3);

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		cell_ctl_t  ctl;
		logic [7:0] shift_in;

		assign ctl.shift  = acc_text;
		assign ctl.clear  = acc_restart;
		assign ctl.pat_we = acc_pattern && (32'(pattern_index) == k);

		// newest byte enters cell 0 and moves up one cell per text item
		if (k == 0) begin : g_head
			assign shift_in = char_value;
		end else begin : g_body
			assign shift_in = chain[k-1];
		end

		assign win_rev[(PATTERN_MAX-1-k)*8 +: 8] = chain[k];

		wpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.shift_in  (shift_in),
			.pat_in    (char_value),
			.joker     (joker_q),
			.in_use    (32'(len_eff) > k),
			.cmp_text  (aligned[k*8 +: 8]),
			.shift_out (chain[k]),
			.hit_s2    (hit_s2[k])
		);
	end

	// stage 2 bookkeeping: window complete and its start
	logic        txt_s2;
	logic        rst_s2;
	logic        enough_s2;
	logic [31:0] start_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_s2 <= 1'b0;
			rst_s2 <= 1'b0;
		end else begin
			txt_s2 <= txt_s1;
			rst_s2 <= rst_s1;
		end
	end

	always_ff @(posedge clk) begin
		enough_s2 <= (count_q >= 32'(len_eff));
		start_s2  <= count_q - 32'(len_eff) + 32'd1;
	end

	// decision: full window, all positions agree, no overlap with last report
	logic [31:0] last_q;
	logic        overlap;
	logic        report;

	assign overlap = (last_q != '0) && (({1'b0, last_q} + 33'(len_eff)) > {1'b0, start_s2});
	assign report  = txt_s2 && enough_s2 && (&hit_s2) && !overlap;

	// a restart takes effect here in stream order, after earlier text items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (rst_s2) begin
			last_q <= '0;
		end else if (report) begin
			last_q <= start_s2;
		end
	end

	// result queue
	logic [FIFO_CNT_W-1:0] fifo_cnt;

	wpm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (report),
		.push_data (start_s2),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.count     (fifo_cnt)
	);

	// reserve a queue slot for every text item still in flight
	assign s_tready = ((32'(fifo_cnt) + 32'(txt_s1) + 32'(txt_s2)) < FIFO_DEPTH);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		report |-> (32'(fifo_cnt) < FIFO_DEPTH))
		else $error("result queue overflow");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		report |-> (start_s2 != '0))
		else $error("reported start position is zero");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rst_s2 |=> (last_q == '0))
		else $error("restart did not clear last report");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (fifo_cnt != '0))
		else $error("input stalled with empty result queue");
`endif

endmodule
`default_nettype wire
